FILE: src/rsv_pkg.sv
// ----------------------------------------------------------------------------
// rsv_pkg: shared types and constants of the redundant sensor voter
// Sample width, register indexes, lane result type and the divide-by-three
// reciprocal used by the lanes.
// ----------------------------------------------------------------------------
package rsv_pkg;

    localparam int SAMPLE_WIDTH = 8;
    localparam int REG_W        = 8;
    localparam int CFG_IDX_W    = 2;

    // compare width for sample vs. 8-bit register values
    localparam int CMP_W   = (SAMPLE_WIDTH > REG_W) ? SAMPLE_WIDTH : REG_W;
    localparam int SUM2_W  = SAMPLE_WIDTH + 1;
    localparam int SUM3_W  = SAMPLE_WIDTH + 2;

    // floor(x/3) == (x * DIV3_MULT) >> DIV3_SHIFT for x < 2**(DIV3_SHIFT-1);
    // the shift is kept even so 2**shift + 2 divides by three exactly
    localparam int DIV3_SHIFT = SUM3_W + 1 + ((SUM3_W + 1) % 2);
    localparam int DIV3_MULT  = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int DIV3_PROD_W = SUM3_W + DIV3_SHIFT;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd3;

    // reset values
    localparam logic [REG_W-1:0] TOLERANCE_A_RST = 8'd4;
    localparam logic [REG_W-1:0] TOLERANCE_B_RST = 8'd3;
    localparam logic [REG_W-1:0] WINDOW_LOW_RST  = 8'd130;
    localparam logic [REG_W-1:0] WINDOW_HIGH_RST = 8'd134;

    typedef struct packed {
        logic                    ok;
        logic [SAMPLE_WIDTH-1:0] vote;
    } lane_result_t;

endpackage

FILE: src/rsv_lane.sv
// ----------------------------------------------------------------------------
// rsv_lane: inexact majority vote over one triple-redundant group
// Pairwise absolute differences against the group tolerance pick the vote.
// ----------------------------------------------------------------------------
module rsv_lane (
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s1,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s2,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s3,
    input  logic [rsv_pkg::REG_W-1:0]        tolerance,
    output rsv_pkg::lane_result_t            result
);

    logic [rsv_pkg::SAMPLE_WIDTH-1:0] diff12, diff13, diff23;
    logic                             p12, p13, p23;
    logic [rsv_pkg::SUM2_W-1:0]       sum12, sum13, sum23;
    logic [rsv_pkg::SUM3_W-1:0]       sum123;
    logic [rsv_pkg::DIV3_PROD_W-1:0]  prod3;
    logic [rsv_pkg::SAMPLE_WIDTH-1:0] mean3;

    assign diff12 = (s1 >= s2) ? (s1 - s2) : (s2 - s1);
    assign diff13 = (s1 >= s3) ? (s1 - s3) : (s3 - s1);
    assign diff23 = (s2 >= s3) ? (s2 - s3) : (s3 - s2);

    assign p12 = rsv_pkg::CMP_W'(diff12) <= rsv_pkg::CMP_W'(tolerance);
    assign p13 = rsv_pkg::CMP_W'(diff13) <= rsv_pkg::CMP_W'(tolerance);
    assign p23 = rsv_pkg::CMP_W'(diff23) <= rsv_pkg::CMP_W'(tolerance);

    assign sum12  = rsv_pkg::SUM2_W'(s1) + rsv_pkg::SUM2_W'(s2);
    assign sum13  = rsv_pkg::SUM2_W'(s1) + rsv_pkg::SUM2_W'(s3);
    assign sum23  = rsv_pkg::SUM2_W'(s2) + rsv_pkg::SUM2_W'(s3);
    assign sum123 = rsv_pkg::SUM3_W'(s1) + rsv_pkg::SUM3_W'(s2) + rsv_pkg::SUM3_W'(s3);

    // divide by three through the reciprocal
    assign prod3 = rsv_pkg::DIV3_PROD_W'(sum123)
                 * rsv_pkg::DIV3_PROD_W'(rsv_pkg::DIV3_MULT);
    assign mean3 = prod3[rsv_pkg::DIV3_SHIFT +: rsv_pkg::SAMPLE_WIDTH];

    always_comb begin
        result.ok = 1'b1;
        unique case ({p12, p13, p23})
            3'b111:  result.vote = mean3;
            3'b110:  result.vote = s1;
            3'b101:  result.vote = s2;
            3'b011:  result.vote = s3;
            3'b100:  result.vote = sum12[rsv_pkg::SUM2_W-1:1];
            3'b010:  result.vote = sum13[rsv_pkg::SUM2_W-1:1];
            3'b001:  result.vote = sum23[rsv_pkg::SUM2_W-1:1];
            default: begin
                result.ok   = 1'b0;
                result.vote = '0;
            end
        endcase
    end

endmodule

FILE: src/rsv_merge.sv
// ----------------------------------------------------------------------------
// rsv_merge: window check and fusion of the two group votes
// Votes inside the inclusive window are averaged or passed; else zero.
// ----------------------------------------------------------------------------
module rsv_merge (
    input  rsv_pkg::lane_result_t            lane_a,
    input  rsv_pkg::lane_result_t            lane_b,
    input  logic [rsv_pkg::REG_W-1:0]        window_low,
    input  logic [rsv_pkg::REG_W-1:0]        window_high,
    output logic [rsv_pkg::SAMPLE_WIDTH-1:0] fused_value
);

    logic                       in_a, in_b;
    logic [rsv_pkg::SUM2_W-1:0] sum_ab;

    assign in_a = lane_a.ok
               && (rsv_pkg::CMP_W'(lane_a.vote) >= rsv_pkg::CMP_W'(window_low))
               && (rsv_pkg::CMP_W'(lane_a.vote) <= rsv_pkg::CMP_W'(window_high));
    assign in_b = lane_b.ok
               && (rsv_pkg::CMP_W'(lane_b.vote) >= rsv_pkg::CMP_W'(window_low))
               && (rsv_pkg::CMP_W'(lane_b.vote) <= rsv_pkg::CMP_W'(window_high));

    assign sum_ab = rsv_pkg::SUM2_W'(lane_a.vote) + rsv_pkg::SUM2_W'(lane_b.vote);

    always_comb begin
        case ({in_a, in_b})
            2'b11:   fused_value = sum_ab[rsv_pkg::SUM2_W-1:1];
            2'b10:   fused_value = lane_a.vote;
            2'b01:   fused_value = lane_b.vote;
            default: fused_value = '0;
        endcase
    end

endmodule

FILE: src/redundant_sensor_voter_core.sv
// ----------------------------------------------------------------------------
// redundant_sensor_voter_core: two-group inexact majority voter with fusion
// Six samples in, one fused value and two group fail flags out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one item of six samples (groups a and b), accepted
//   when s_valid and s_ready are both high. m_* channel returns one result
//   item per input item, taken when m_valid and m_ready are both high.
//   cfg_wr_en/cfg_index/cfg_wdata write the tolerance and window registers;
//   write them only while no item is in flight.
// Order: an accepted item is registered in the vote stage, then in the
//   output register. Throughput: one item per cycle while m_ready is high.
//   Stage 1 runs the two voter lanes side by side and registers their
//   votes; stage 2 does the window check and fusion into the output register.
// Stall: when m_ready is low the output register holds; the vote stage still
//   takes one more item if it is empty, after that s_ready drops.
// Reset: aresetn (synchronous, active low) empties both stages and loads the
//   register defaults (tolerances 4 and 3, window 130..134).
// ----------------------------------------------------------------------------
module redundant_sensor_voter_core (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [rsv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsv_pkg::REG_W-1:0]        cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s_sample_a1,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s_sample_a2,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s_sample_a3,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s_sample_b1,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s_sample_b2,
    input  logic [rsv_pkg::SAMPLE_WIDTH-1:0] s_sample_b3,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rsv_pkg::SAMPLE_WIDTH-1:0] m_fused_value,
    output logic                             m_group_a_fail,
    output logic                             m_group_b_fail
);

    // configuration registers
    logic [rsv_pkg::REG_W-1:0] tolerance_a_reg, tolerance_b_reg;
    logic [rsv_pkg::REG_W-1:0] window_low_reg, window_high_reg;

    // stage 1: lane votes
    logic                  vote_valid_reg;
    rsv_pkg::lane_result_t lane_a_reg, lane_b_reg;
    rsv_pkg::lane_result_t lane_a_next, lane_b_next;

    // stage 2: output register
    logic                             out_valid_reg;
    logic [rsv_pkg::SAMPLE_WIDTH-1:0] fused_reg, fused_next;
    logic                             a_fail_reg, b_fail_reg;

    logic out_adv, vote_adv, s_accept;

    assign out_adv  = !out_valid_reg || m_ready;
    assign vote_adv = !vote_valid_reg || out_adv;
    assign s_ready  = vote_adv;
    assign s_accept = s_valid && vote_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_a_reg <= rsv_pkg::TOLERANCE_A_RST;
            tolerance_b_reg <= rsv_pkg::TOLERANCE_B_RST;
            window_low_reg  <= rsv_pkg::WINDOW_LOW_RST;
            window_high_reg <= rsv_pkg::WINDOW_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rsv_pkg::REG_TOLERANCE_A: tolerance_a_reg <= cfg_wdata;
                rsv_pkg::REG_TOLERANCE_B: tolerance_b_reg <= cfg_wdata;
                rsv_pkg::REG_WINDOW_LOW:  window_low_reg  <= cfg_wdata;
                rsv_pkg::REG_WINDOW_HIGH: window_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // the two voter lanes
    rsv_lane u_lane_a (
        .s1        (s_sample_a1),
        .s2        (s_sample_a2),
        .s3        (s_sample_a3),
        .tolerance (tolerance_a_reg),
        .result    (lane_a_next)
    );

    rsv_lane u_lane_b (
        .s1        (s_sample_b1),
        .s2        (s_sample_b2),
        .s3        (s_sample_b3),
        .tolerance (tolerance_b_reg),
        .result    (lane_b_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_valid_reg <= 1'b0;
        end else if (vote_adv) begin
            vote_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
        end
    end

    // window check and fusion
    rsv_merge u_merge (
        .lane_a      (lane_a_reg),
        .lane_b      (lane_b_reg),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .fused_value (fused_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= vote_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && vote_valid_reg) begin
            fused_reg  <= fused_next;
            a_fail_reg <= !lane_a_reg.ok;
            b_fail_reg <= !lane_b_reg.ok;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_fused_value  = fused_reg;
    assign m_group_a_fail = a_fail_reg;
    assign m_group_b_fail = b_fail_reg;

    // an empty vote stage always takes an item
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vote_valid_reg |-> s_ready)
        else $error("s_ready low with empty vote stage");

    // an accepted item lands in the vote stage
    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vote_valid_reg)
        else $error("accepted item lost before vote stage");

    // a vote moving on shows up as a result next cycle
    a_vote_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        vote_valid_reg && out_adv |=> m_valid)
        else $error("vote stage item lost before output");

    // both groups failed means no usable vote
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_group_a_fail && m_group_b_fail |-> m_fused_value == '0)
        else $error("nonzero fused value with both groups failed");

endmodule
